// ===== design/frlc_pkg.sv =====
package frlc_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int ADDR_W        = 32;
  localparam int COUNT_OUT_W   = 5;
  localparam int FUNC_W        = 2;
  localparam int STATUS_W      = 2;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CUT    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd2;

endpackage

// ===== design/frlc_ram.sv =====
module frlc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/free_range_list_cutter.sv =====
// Free range list cutter: holds an ordered list of up to LIST_DEPTH free
// address ranges (inclusive first and last address) in two small RAMs and
// answers every input transfer with exactly one result transfer carrying the
// entry count after the operation (modulo 32) and a status code. A cut walks
// the list through the single RAM read port: one pass looking for a start
// match, an end match and a containing entry (stopping early on a start
// match), then an entry shift for a drop or a split, then a merge pass with
// at most one more drop. The block takes no new input while a cut is under
// way; it does take one while a finished result still waits.
module free_range_list_cutter #(
  parameter int LIST_DEPTH = frlc_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [frlc_pkg::FUNC_W-1:0]       in_func,
  input  logic [frlc_pkg::ADDR_W-1:0]       in_range_start,
  input  logic [frlc_pkg::ADDR_W-1:0]       in_range_end,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [frlc_pkg::COUNT_OUT_W-1:0]  out_entry_count,
  output logic [frlc_pkg::STATUS_W-1:0]     out_status
);

  localparam int IDX_W = $clog2(LIST_DEPTH);
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int AW    = frlc_pkg::ADDR_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_CUT_APPLY,
    S_DROP_RD,
    S_DROP_WR,
    S_SPLIT_RD,
    S_SPLIT_WR,
    S_SPLIT_LO,
    S_SPLIT_HI,
    S_MERGE_RD,
    S_MERGE_CHK,
    S_DONE
  } state_t;

  state_t                           state_r, state_nxt;
  logic [CNT_W-1:0]                 count_r, count_nxt;
  logic [AW-1:0]                    s_r, s_nxt, e_r, e_nxt;
  logic [CNT_W-1:0]                 ptr_r, ptr_nxt;
  logic [CNT_W-1:0]                 k_r, k_nxt;
  logic [CNT_W-1:0]                 idx1_r, idx1_nxt, idx2_r, idx2_nxt, idx3_r, idx3_nxt;
  logic [AW-1:0]                    v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt;
  logic                             hit1_r, hit1_nxt, hit2_r, hit2_nxt, hit3_r, hit3_nxt;
  logic                             from_merge_r, from_merge_nxt;
  logic [AW-1:0]                    prev_last_r, prev_last_nxt;
  logic [frlc_pkg::STATUS_W-1:0]    status_r, status_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [frlc_pkg::COUNT_OUT_W-1:0] out_count_r, out_count_nxt;
  logic [frlc_pkg::STATUS_W-1:0]    out_status_r, out_status_nxt;

  // RAM port controls: one read address and one write address shared by
  // both arrays, separate write enables.
  logic [IDX_W-1:0] raddr, waddr;
  logic             we_first, we_last;
  logic [AW-1:0]    wdata_first, wdata_last;
  logic [AW-1:0]    rdata_first, rdata_last;

  logic [CNT_W-1:0] k_inc, k_dec, ptr_dec, idx3_inc;

  assign k_inc    = k_r + 1'b1;
  assign k_dec    = k_r - 1'b1;
  assign ptr_dec  = ptr_r - 1'b1;
  assign idx3_inc = idx3_r + 1'b1;

  frlc_ram #(.WIDTH(AW), .DEPTH(LIST_DEPTH)) u_first_ram (
    .clk   (clk),
    .we    (we_first),
    .waddr (waddr),
    .wdata (wdata_first),
    .raddr (raddr),
    .rdata (rdata_first)
  );

  frlc_ram #(.WIDTH(AW), .DEPTH(LIST_DEPTH)) u_last_ram (
    .clk   (clk),
    .we    (we_last),
    .waddr (waddr),
    .wdata (wdata_last),
    .raddr (raddr),
    .rdata (rdata_last)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    s_nxt          = s_r;
    e_nxt          = e_r;
    ptr_nxt        = ptr_r;
    k_nxt          = k_r;
    idx1_nxt       = idx1_r;
    idx2_nxt       = idx2_r;
    idx3_nxt       = idx3_r;
    v1_nxt         = v1_r;
    v2_nxt         = v2_r;
    v3_nxt         = v3_r;
    hit1_nxt       = hit1_r;
    hit2_nxt       = hit2_r;
    hit3_nxt       = hit3_r;
    from_merge_nxt = from_merge_r;
    prev_last_nxt  = prev_last_r;
    status_nxt     = status_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    // Drop the waiting result once the far side takes it.
    out_valid_nxt  = out_valid_r && out_stall;

    raddr       = '0;
    waddr       = '0;
    we_first    = 1'b0;
    we_last     = 1'b0;
    wdata_first = '0;
    wdata_last  = '0;
    in_stall    = (state_r != S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt  = S_DONE;
          status_nxt = frlc_pkg::ST_OK;
          unique case (in_func)
            frlc_pkg::FUNC_CLEAR: begin
              count_nxt = '0;
            end
            frlc_pkg::FUNC_APPEND: begin
              if (count_r < CNT_W'(LIST_DEPTH)) begin
                waddr       = count_r[IDX_W-1:0];
                we_first    = 1'b1;
                we_last     = 1'b1;
                wdata_first = in_range_start;
                wdata_last  = in_range_end;
                count_nxt   = count_r + 1'b1;
              end else begin
                status_nxt = frlc_pkg::ST_FULL;
              end
            end
            frlc_pkg::FUNC_CUT: begin
              s_nxt          = in_range_start;
              e_nxt          = in_range_end;
              ptr_nxt        = '0;
              hit1_nxt       = 1'b0;
              hit2_nxt       = 1'b0;
              hit3_nxt       = 1'b0;
              from_merge_nxt = 1'b0;
              state_nxt      = S_SCAN_RD;
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN_RD: begin
        if (ptr_r >= count_r) begin
          state_nxt = S_CUT_APPLY;
        end else begin
          raddr     = ptr_r[IDX_W-1:0];
          state_nxt = S_SCAN_CHK;
        end
      end

      S_SCAN_CHK: begin
        if (rdata_first == s_r) begin
          // A start match wins over everything: stop the pass here.
          hit1_nxt  = 1'b1;
          idx1_nxt  = ptr_r;
          v1_nxt    = rdata_last;
          state_nxt = S_CUT_APPLY;
        end else begin
          if (!hit2_r && rdata_last == e_r) begin
            hit2_nxt = 1'b1;
            idx2_nxt = ptr_r;
            v2_nxt   = rdata_first;
          end
          if (!hit3_r && s_r > rdata_first && e_r < rdata_last) begin
            hit3_nxt = 1'b1;
            idx3_nxt = ptr_r;
            v3_nxt   = rdata_last;
          end
          ptr_nxt   = ptr_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end

      S_CUT_APPLY: begin
        from_merge_nxt = 1'b0;
        ptr_nxt        = '0;
        priority if (hit1_r) begin
          if (e_r >= v1_r) begin
            k_nxt     = idx1_r;
            state_nxt = S_DROP_RD;
          end else begin
            waddr       = idx1_r[IDX_W-1:0];
            we_first    = 1'b1;
            wdata_first = e_r + 1'b1;
            state_nxt   = S_MERGE_RD;
          end
        end else if (hit2_r) begin
          if (s_r <= v2_r) begin
            k_nxt     = idx2_r;
            state_nxt = S_DROP_RD;
          end else begin
            waddr      = idx2_r[IDX_W-1:0];
            we_last    = 1'b1;
            wdata_last = s_r - 1'b1;
            state_nxt  = S_MERGE_RD;
          end
        end else if (hit3_r) begin
          if (count_r >= CNT_W'(LIST_DEPTH)) begin
            status_nxt = frlc_pkg::ST_FULL;
            state_nxt  = S_DONE;
          end else begin
            k_nxt     = count_r;
            state_nxt = S_SPLIT_RD;
          end
        end else begin
          status_nxt = frlc_pkg::ST_NOMATCH;
          state_nxt  = S_DONE;
        end
      end

      // Shift entries above k down by one, then shrink the list.
      S_DROP_RD: begin
        if (k_inc >= count_r) begin
          count_nxt = count_r - 1'b1;
          if (from_merge_r) begin
            state_nxt = S_DONE;
          end else begin
            ptr_nxt   = '0;
            state_nxt = S_MERGE_RD;
          end
        end else begin
          raddr     = k_inc[IDX_W-1:0];
          state_nxt = S_DROP_WR;
        end
      end

      S_DROP_WR: begin
        waddr       = k_r[IDX_W-1:0];
        we_first    = 1'b1;
        we_last     = 1'b1;
        wdata_first = rdata_first;
        wdata_last  = rdata_last;
        k_nxt       = k_inc;
        state_nxt   = S_DROP_RD;
      end

      // Open a hole above the split entry, working down from the tail.
      S_SPLIT_RD: begin
        if (k_r > idx3_inc) begin
          raddr     = k_dec[IDX_W-1:0];
          state_nxt = S_SPLIT_WR;
        end else begin
          state_nxt = S_SPLIT_LO;
        end
      end

      S_SPLIT_WR: begin
        waddr       = k_r[IDX_W-1:0];
        we_first    = 1'b1;
        we_last     = 1'b1;
        wdata_first = rdata_first;
        wdata_last  = rdata_last;
        k_nxt       = k_dec;
        state_nxt   = S_SPLIT_RD;
      end

      S_SPLIT_LO: begin
        waddr       = idx3_inc[IDX_W-1:0];
        we_first    = 1'b1;
        we_last     = 1'b1;
        wdata_first = e_r + 1'b1;
        wdata_last  = v3_r;
        state_nxt   = S_SPLIT_HI;
      end

      S_SPLIT_HI: begin
        waddr      = idx3_r[IDX_W-1:0];
        we_last    = 1'b1;
        wdata_last = s_r - 1'b1;
        count_nxt  = count_r + 1'b1;
        ptr_nxt    = '0;
        state_nxt  = S_MERGE_RD;
      end

      S_MERGE_RD: begin
        if (ptr_r >= count_r) begin
          state_nxt = S_DONE;
        end else begin
          raddr     = ptr_r[IDX_W-1:0];
          state_nxt = S_MERGE_CHK;
        end
      end

      S_MERGE_CHK: begin
        if (ptr_r != '0 && prev_last_r != '1 && prev_last_r + 1'b1 == rdata_first) begin
          // Extend the lower entry to the later end, then drop the upper one.
          waddr          = ptr_dec[IDX_W-1:0];
          we_last        = 1'b1;
          wdata_last     = rdata_last;
          k_nxt          = ptr_r;
          from_merge_nxt = 1'b1;
          state_nxt      = S_DROP_RD;
        end else begin
          prev_last_nxt = rdata_last;
          ptr_nxt       = ptr_r + 1'b1;
          state_nxt     = S_MERGE_RD;
        end
      end

      S_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_count_nxt  = frlc_pkg::COUNT_OUT_W'(count_r);
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    s_r          <= s_nxt;
    e_r          <= e_nxt;
    ptr_r        <= ptr_nxt;
    k_r          <= k_nxt;
    idx1_r       <= idx1_nxt;
    idx2_r       <= idx2_nxt;
    idx3_r       <= idx3_nxt;
    v1_r         <= v1_nxt;
    v2_r         <= v2_nxt;
    v3_r         <= v3_nxt;
    hit1_r       <= hit1_nxt;
    hit2_r       <= hit2_nxt;
    hit3_r       <= hit3_nxt;
    from_merge_r <= from_merge_nxt;
    prev_last_r  <= prev_last_nxt;
    status_r     <= status_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_entry_count = out_count_r;
  assign out_status      = out_status_r;

  // The list never holds more entries than it has room for.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(LIST_DEPTH))
    else $error("entry count beyond list depth");

  // A clear transfer empties the list at once.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_func == frlc_pkg::FUNC_CLEAR) |=> (count_r == '0))
    else $error("clear did not empty the list");

  // An append transfer with room grows the list by exactly one entry.
  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_func == frlc_pkg::FUNC_APPEND &&
     count_r < CNT_W'(LIST_DEPTH)) |=> (count_r == $past(count_r) + 1'b1))
    else $error("append did not add one entry");

endmodule
